// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);
// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif

`endif

// ===== rtl/safs_pkg.sv =====
// ---------------------------------------------------------------------------
// Slot allocator package
// Sizes, operation and status codes, sequencer types shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package safs_pkg;

    // Pool size and derived widths.
    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Fixed widths of the word fields.
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 6;
    localparam int STAT_W    = 2;
    localparam int GRANT_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_CLEAR   = 2'd2,
        FN_REBUILD = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_INACTIVE = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CHECK,
        S_SCAN,
        S_DONE
    } seq_state_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic  accept;
        func_t func;
        logic  stack_empty;
        logic  scan_end;
        logic  out_room;
    } seq_in_t;

    // Phase controls from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic pop_phase;
        logic check_phase;
        logic scan_phase;
        logic emit;
    } seq_out_t;

endpackage

`default_nettype wire

// ===== rtl/safs_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module safs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/safs_seq.sv =====
// ---------------------------------------------------------------------------
// Slot allocator sequencer
// Steps each operation through its read, scan and result phases.
// ---------------------------------------------------------------------------
`default_nettype none

module safs_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire safs_pkg::seq_in_t  seq_i,
    output safs_pkg::seq_out_t      seq_o
);

    safs_pkg::seq_state_t state_reg;
    safs_pkg::seq_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= safs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            safs_pkg::S_IDLE: begin
                if (seq_i.accept) begin
                    if (seq_i.func == safs_pkg::FN_REBUILD) begin
                        state_next = safs_pkg::S_SCAN;
                    end else if (seq_i.func == safs_pkg::FN_FREE) begin
                        state_next = safs_pkg::S_CHECK;
                    end else if (seq_i.func == safs_pkg::FN_ALLOC &&
                                 !seq_i.stack_empty) begin
                        state_next = safs_pkg::S_POP;
                    end else begin
                        state_next = safs_pkg::S_DONE;
                    end
                end
            end
            safs_pkg::S_POP: begin
                state_next = safs_pkg::S_DONE;
            end
            safs_pkg::S_CHECK: begin
                state_next = safs_pkg::S_DONE;
            end
            safs_pkg::S_SCAN: begin
                if (seq_i.scan_end) begin
                    state_next = safs_pkg::S_DONE;
                end
            end
            safs_pkg::S_DONE: begin
                if (seq_i.out_room) begin
                    state_next = safs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = safs_pkg::S_IDLE;
            end
        endcase
    end

    // Phase outputs.
    always_comb begin
        seq_o = '0;
        case (state_reg)
            safs_pkg::S_IDLE:  seq_o.in_ready    = 1'b1;
            safs_pkg::S_POP:   seq_o.pop_phase   = 1'b1;
            safs_pkg::S_CHECK: seq_o.check_phase = 1'b1;
            safs_pkg::S_SCAN:  seq_o.scan_phase  = 1'b1;
            safs_pkg::S_DONE:  seq_o.emit        = seq_i.out_room;
            default:           seq_o = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/slot_allocator_free_stack.sv =====
// Sequence: an allocate at the high-water mark and a clear go from acceptance straight to
// the result state; an allocate from the freed stack passes the pop state, a free the check
// state, and a rebuild the scan state, which reads one slot per cycle up to the mark. A new
// word is taken only in the idle state, once the previous reply is in the output register.
// Reset: aresetn low clears stack top, high-water mark, output valid and the sequencer at
// once; neither RAM is cleared, since only entries below the top and the mark are read.
// ---------------------------------------------------------------------------
// Slot allocator with freed-slot stack
// Allocates, frees, clears and rebuilds a free list over a fixed slot pool.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slot_allocator_free_stack (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] func, [7:2] slot_index
    input  wire logic [safs_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] status, [7:2] granted_slot, [14:8] freed_count, [21:15] high_water
    output logic      [safs_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int SW = safs_pkg::SLOT_W;
    localparam int CW = safs_pkg::CNT_W;

    safs_pkg::seq_in_t  seq_i;
    safs_pkg::seq_out_t seq_o;

    logic [CW-1:0]              top_reg, top_next;
    logic [CW-1:0]              wm_reg, wm_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [SW-1:0]              slot_reg, slot_next;
    safs_pkg::status_t          status_reg, status_next;
    logic [SW-1:0]              granted_reg, granted_next;
    logic                       m_valid_reg, m_valid_next;
    logic [safs_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                       accept;
    logic                       pop_start;
    safs_pkg::func_t            in_func;
    logic [safs_pkg::IDX_W-1:0] in_idx;
    logic [SW-1:0]              in_slot;
    logic [CW-1:0]              top_dec;
    logic                       scan_end;
    logic                       slot_live;
    logic                       ram_we;
    logic [SW-1:0]              ram_waddr;
    logic [SW-1:0]              ram_wdata;
    logic [SW-1:0]              ram_rdata;
    logic                       act_we;
    logic [SW-1:0]              act_waddr;
    logic                       act_wdata;
    logic [SW-1:0]              act_raddr;
    logic                       act_rdata;

    // Input word fields.
    assign accept    = s_tvalid && s_tready;
    assign in_func   = safs_pkg::func_t'(s_tdata[1:0]);
    assign in_idx    = s_tdata[7:2];
    assign in_slot   = SW'(in_idx);
    assign top_dec   = top_reg - CW'(1);
    assign scan_end  = (scan_reg >= wm_reg);
    assign s_tready  = seq_o.in_ready;
    assign pop_start = accept && in_func == safs_pkg::FN_ALLOC && top_reg != '0;

    // A slot at or above the mark is inactive whatever its stored bit says.
    assign slot_live = (CW'(slot_reg) < wm_reg);

    // Sequencer.
    assign seq_i.accept      = accept;
    assign seq_i.func        = in_func;
    assign seq_i.stack_empty = (top_reg == '0);
    assign seq_i.scan_end    = scan_end;
    assign seq_i.out_room    = !m_valid_reg || m_tready;

    safs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq_i   (seq_i),
        .seq_o   (seq_o)
    );

    // Freed-slot stack storage.
    safs_ram #(
        .WIDTH (SW),
        .DEPTH (safs_pkg::SLOTS)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (top_dec[SW-1:0]),
        .rdata (ram_rdata)
    );

    // Activity bits: the slot of a free is read as the word is taken, and the
    // scan reads one slot ahead so each bit arrives with its scan step.
    assign act_raddr = (seq_o.in_ready && in_func == safs_pkg::FN_FREE) ?
                       in_slot : scan_next[SW-1:0];

    safs_ram #(
        .WIDTH (1),
        .DEPTH (safs_pkg::SLOTS)
    ) u_active (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    // Datapath: slot bookkeeping for each phase of an operation.
    always_comb begin
        top_next     = top_reg;
        wm_next      = wm_reg;
        scan_next    = scan_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        ram_we       = 1'b0;
        ram_waddr    = top_reg[SW-1:0];
        ram_wdata    = slot_reg;
        act_we       = 1'b0;
        act_waddr    = wm_reg[SW-1:0];
        act_wdata    = 1'b1;

        if (accept) begin
            status_next  = safs_pkg::STAT_OK;
            granted_next = '0;
            case (in_func)
                safs_pkg::FN_ALLOC: begin
                    // With a non-empty stack the pop finishes in the next phase.
                    if (top_reg == '0) begin
                        if (int'(wm_reg) < safs_pkg::SLOTS) begin
                            granted_next = wm_reg[SW-1:0];
                            act_we       = 1'b1;
                            wm_next      = wm_reg + CW'(1);
                        end else begin
                            status_next = safs_pkg::STAT_FULL;
                        end
                    end
                end
                safs_pkg::FN_FREE: begin
                    // The activity bit is checked in the next phase.
                    slot_next = in_slot;
                end
                safs_pkg::FN_CLEAR: begin
                    // Dropping the mark retires every slot at once.
                    wm_next  = '0;
                    top_next = '0;
                end
                safs_pkg::FN_REBUILD: begin
                    top_next  = '0;
                    scan_next = '0;
                end
                default: begin
                    status_next = safs_pkg::STAT_OK;
                end
            endcase
        end else if (seq_o.pop_phase) begin
            // Read data is the stack entry just below the top.
            granted_next = ram_rdata;
            act_we       = 1'b1;
            act_waddr    = ram_rdata;
            top_next     = top_dec;
        end else if (seq_o.check_phase) begin
            // Free an active slot and push it, otherwise report it inactive.
            if (slot_live && act_rdata) begin
                act_we    = 1'b1;
                act_waddr = slot_reg;
                act_wdata = 1'b0;
                if (int'(top_reg) < safs_pkg::SLOTS) begin
                    ram_we   = 1'b1;
                    top_next = top_reg + CW'(1);
                end
            end else begin
                status_next = safs_pkg::STAT_INACTIVE;
            end
        end else if (seq_o.scan_phase && !scan_end) begin
            // Push each inactive slot below the mark, one slot per cycle.
            ram_wdata = scan_reg[SW-1:0];
            if (!act_rdata && int'(top_reg) < safs_pkg::SLOTS) begin
                ram_we   = 1'b1;
                top_next = top_reg + CW'(1);
            end
            scan_next = scan_reg + CW'(1);
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (seq_o.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[1:0]   = status_reg;
            m_data_next[7:2]   = safs_pkg::GRANT_W'(granted_reg);
            m_data_next[14:8]  = safs_pkg::COUNT_W'(top_reg);
            m_data_next[21:15] = safs_pkg::COUNT_W'(wm_reg);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            wm_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            top_reg     <= top_next;
            wm_reg      <= wm_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        m_data_reg  <= m_data_next;
    end

    // Freed entries are distinct slots below the mark, so the stack top never passes the mark.
    `ASSERT_ALWAYS(a_top_le_mark, aclk, aresetn, top_reg <= wm_reg, "stack above mark")
    // The mark never passes the pool size.
    `ASSERT_ALWAYS(a_mark_le_slots, aclk, aresetn, int'(wm_reg) <= safs_pkg::SLOTS, "mark overflow")
    // An allocate with a non-empty stack goes through the pop phase.
    `ASSERT_NEXT(a_alloc_pop, aclk, aresetn, pop_start, seq_o.pop_phase, "pop phase missed")

endmodule

`default_nettype wire

// ===== verif/slot_allocator_free_stack_tb.sv =====
// ---------------------------------------------------------------------------
// Slot allocator free-stack testbench
// Drives allocate, free, clear and rebuild words into the allocator, predicts
// each reply from a local copy of the pool, the freed-slot LIFO and the
// high-water mark or reads it from the table, and compares each reply word
// field by field. A short directed table covers the corner cases, then a long
// random run follows with bursty input, a stalling receiver and drain pauses.
// ---------------------------------------------------------------------------
`default_nettype none

module slot_allocator_free_stack_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = safs_pkg::SLOTS;
    localparam int SLOT_W   = safs_pkg::SLOT_W;
    localparam int IDX_W    = safs_pkg::IDX_W;
    localparam int STAT_W   = safs_pkg::STAT_W;
    localparam int GRANT_W  = safs_pkg::GRANT_W;
    localparam int COUNT_W  = safs_pkg::COUNT_W;
    localparam int S_DATA_W = safs_pkg::S_DATA_W;
    localparam int M_DATA_W = safs_pkg::M_DATA_W;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = SLOTS + 40;
    localparam int REPORT_MAX   = 10;

    // The fields of one reply word, without the zero padding.
    typedef struct packed {
        safs_pkg::status_t    status;
        logic [GRANT_W-1:0]   slot;
        logic [COUNT_W-1:0]   count;
        logic [COUNT_W-1:0]   mark;
    } reply_t;

    // One row of the directed table.
    typedef struct {
        safs_pkg::func_t    op;
        logic [IDX_W-1:0]   idx;
        int                 reps;
        bit                 typed;
        reply_t             want;
    } plan_row_t;

    // Receiver stall styles.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    localparam int PLAN_ROWS = 23;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Block ports.
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Predicted pool state.
    logic [SLOTS-1:0]      pool_active;
    logic [SLOT_W-1:0]     freed_lifo [SLOTS];
    int                    lifo_depth;
    int                    mark_level;

    // Replies still owed by the block, oldest first.
    reply_t                owed_replies [$];

    // Sender burst state.
    int                    burst_left = 0;

    // Receiver state.
    int                    rx_cycles  = 0;
    int                    hold_left  = 0;
    int                    mode_left  = 0;
    rx_mode_t              rx_mode    = RX_OPEN;

    // Run statistics.
    int                    cycle_count    = 0;
    int                    mismatch_count = 0;
    int                    checked_count  = 0;
    int                    op_count [4]   = '{0, 0, 0, 0};
    int                    full_count     = 0;
    int                    ignored_count  = 0;
    int                    long_holds     = 0;
    int                    drain_pauses   = 0;

    plan_row_t             plan [PLAN_ROWS];

    slot_allocator_free_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one operation to the predicted pool and returns the reply it gives.
    function automatic reply_t apply_slot_op(safs_pkg::func_t op, logic [IDX_W-1:0] idx);
        reply_t r;
        r.status = safs_pkg::STAT_OK;
        r.slot   = '0;
        case (op)
            safs_pkg::FN_ALLOC: begin
                if (lifo_depth > 0) begin
                    lifo_depth--;
                    r.slot = freed_lifo[lifo_depth];
                    pool_active[r.slot] = 1'b1;
                end else if (mark_level < SLOTS) begin
                    r.slot = mark_level[GRANT_W-1:0];
                    pool_active[r.slot] = 1'b1;
                    mark_level++;
                end else begin
                    r.status = safs_pkg::STAT_FULL;
                end
            end
            safs_pkg::FN_FREE: begin
                if (pool_active[idx]) begin
                    pool_active[idx] = 1'b0;
                    if (lifo_depth < SLOTS) begin
                        freed_lifo[lifo_depth] = idx;
                        lifo_depth++;
                    end
                end else begin
                    r.status = safs_pkg::STAT_INACTIVE;
                end
            end
            safs_pkg::FN_CLEAR: begin
                pool_active = '0;
                mark_level  = 0;
                lifo_depth  = 0;
            end
            default: begin
                // Rebuild refills the stack in ascending slot order.
                lifo_depth = 0;
                for (int i = 0; i < mark_level && i < SLOTS; i++) begin
                    if (!pool_active[i] && lifo_depth < SLOTS) begin
                        freed_lifo[lifo_depth] = i[SLOT_W-1:0];
                        lifo_depth++;
                    end
                end
            end
        endcase
        r.count = lifo_depth[COUNT_W-1:0];
        r.mark  = mark_level[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one word, with a random gap at the start of most bursts, and
    // records the expected reply once the block takes it.
    task automatic send_word(input safs_pkg::func_t op, input logic [IDX_W-1:0] idx,
                             input bit typed, input reply_t want);
        reply_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_slot_op(op, idx);
        owed_replies.push_back(typed ? want : r);
        op_count[op]++;
        if (r.status == safs_pkg::STAT_FULL) full_count++;
        if (r.status == safs_pkg::STAT_INACTIVE) ignored_count++;
    endtask

    // Directed table: reset state, LIFO order, full pool, rebuild order,
    // clear, and frees of inactive slots above and at the mark.
    initial begin
        plan[0]  = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd1}};
        plan[1]  = '{safs_pkg::FN_FREE, 6'd63, 1, 1'b1,
                     '{safs_pkg::STAT_INACTIVE, 6'd0, 7'd0, 7'd1}};
        plan[2]  = '{safs_pkg::FN_FREE, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd1, 7'd1}};
        plan[3]  = '{safs_pkg::FN_FREE, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_INACTIVE, 6'd0, 7'd1, 7'd1}};
        plan[4]  = '{safs_pkg::FN_ALLOC, 6'd63, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd1}};
        plan[5]  = '{safs_pkg::FN_REBUILD, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd1}};
        plan[6]  = '{safs_pkg::FN_ALLOC, 6'd0, 63, 1'b0,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd0}};
        plan[7]  = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_FULL, 6'd0, 7'd0, 7'd64}};
        plan[8]  = '{safs_pkg::FN_FREE, 6'd63, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd1, 7'd64}};
        plan[9]  = '{safs_pkg::FN_FREE, 6'd42, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd2, 7'd64}};
        plan[10] = '{safs_pkg::FN_FREE, 6'd21, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd3, 7'd64}};
        plan[11] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd21, 7'd2, 7'd64}};
        plan[12] = '{safs_pkg::FN_FREE, 6'd7, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd3, 7'd64}};
        plan[13] = '{safs_pkg::FN_REBUILD, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd3, 7'd64}};
        plan[14] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd63, 7'd2, 7'd64}};
        plan[15] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd42, 7'd1, 7'd64}};
        plan[16] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd7, 7'd0, 7'd64}};
        plan[17] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_FULL, 6'd0, 7'd0, 7'd64}};
        plan[18] = '{safs_pkg::FN_CLEAR, 6'd45, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd0}};
        plan[19] = '{safs_pkg::FN_FREE, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_INACTIVE, 6'd0, 7'd0, 7'd0}};
        plan[20] = '{safs_pkg::FN_REBUILD, 6'd63, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd0}};
        plan[21] = '{safs_pkg::FN_ALLOC, 6'd0, 1, 1'b1,
                     '{safs_pkg::STAT_OK, 6'd0, 7'd0, 7'd1}};
        plan[22] = '{safs_pkg::FN_FREE, 6'd1, 1, 1'b1,
                     '{safs_pkg::STAT_INACTIVE, 6'd0, 7'd0, 7'd1}};
    end

    // Stimulus: reset, directed table, then the random run.
    initial begin : stimulus
        safs_pkg::func_t    op;
        logic [IDX_W-1:0]   idx;
        int                 alloc_bias;
        int                 roll;
        int                 start;
        int                 pick;
        pool_active = '0;
        lifo_depth  = 0;
        mark_level  = 0;
        alloc_bias  = 50;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < PLAN_ROWS; row++) begin
            for (int k = 0; k < plan[row].reps; k++) begin
                send_word(plan[row].op, plan[row].idx, plan[row].typed, plan[row].want);
            end
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // The allocate share drifts so the pool both fills and empties.
            if (n % 128 == 0) alloc_bias = $urandom_range(15, 90);

            // Now and then the sender waits for every reply to come back.
            if (n % 300 == 150) begin
                s_tvalid <= 1'b0;
                while (owed_replies.size() != 0) @(posedge aclk);
                @(posedge aclk);
                drain_pauses++;
            end

            roll = $urandom_range(0, 199);
            idx  = IDX_W'($urandom_range(0, SLOTS - 1));
            if (roll == 0) begin
                op = safs_pkg::FN_CLEAR;
            end else if (roll < 9) begin
                op = safs_pkg::FN_REBUILD;
            end else if (roll < 25) begin
                op = safs_pkg::FN_FREE;
            end else if ($urandom_range(0, 99) < alloc_bias) begin
                op = safs_pkg::FN_ALLOC;
            end else begin
                // Free a slot that is currently held, if there is one.
                start = $urandom_range(0, SLOTS - 1);
                pick  = -1;
                for (int k = 0; k < SLOTS; k++) begin
                    if (pick < 0 && pool_active[(start + k) % SLOTS]) pick = (start + k) % SLOTS;
                end
                if (pick < 0) begin
                    op = safs_pkg::FN_ALLOC;
                end else begin
                    op  = safs_pkg::FN_FREE;
                    idx = pick[IDX_W-1:0];
                end
            end
            send_word(op, idx, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Wait for the last replies, then keep the clock running so any stray reply is caught.
        while (owed_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (owed_replies.size() != 0) begin
            mismatch_count += owed_replies.size();
            $display("missing: %0d replies never arrived", owed_replies.size());
        end

        $display("summary: %0d replies checked: %0d allocate, %0d free, %0d clear, %0d rebuild",
                 checked_count, op_count[safs_pkg::FN_ALLOC], op_count[safs_pkg::FN_FREE],
                 op_count[safs_pkg::FN_CLEAR], op_count[safs_pkg::FN_REBUILD]);
        $display("summary: %0d pool-full, %0d ignored frees, %0d long holds, %0d drains",
                 full_count, ignored_count, long_holds, drain_pauses);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: changing stall styles, plus a recurring long hold so the block backs
    // up and stalls its input.
    always @(posedge aclk) begin
        rx_cycles++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_cycles % 5000 == 1000) begin
            hold_left = 299;
            long_holds++;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_tready <= (rx_cycles % 5) < 3;
                default:    m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Reply checker: each accepted word against the oldest expectation.
    always @(posedge aclk) begin : reply_check
        reply_t                 want;
        logic [STAT_W-1:0]      got_status;
        logic [GRANT_W-1:0]     got_slot;
        logic [COUNT_W-1:0]     got_count;
        logic [COUNT_W-1:0]     got_mark;
        logic [1:0]             got_pad;
        got_status = m_tdata[1:0];
        got_slot   = m_tdata[7:2];
        got_count  = m_tdata[14:8];
        got_mark   = m_tdata[21:15];
        got_pad    = m_tdata[23:22];
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected reply word %h at cycle %0d", m_tdata, cycle_count);
            end else begin
                want = owed_replies.pop_front();
                checked_count++;
                if (got_status !== want.status || got_slot !== want.slot ||
                    got_count !== want.count || got_mark !== want.mark || got_pad !== 2'b00) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch at cycle %0d: code exp %0d got %0d, slot exp %0d ",
                                  "got %0d, stack exp %0d got %0d, mark exp %0d got %0d, pad %b"},
                                 cycle_count, want.status, got_status, want.slot, got_slot,
                                 want.count, got_count, want.mark, got_mark, got_pad);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire
